// File: hdl/gossip_view_merge_core_macros.svh
// Assertion macros for the gossip view merge core.
`ifndef GOSSIP_VIEW_MERGE_CORE_MACROS_SVH
`define GOSSIP_VIEW_MERGE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Checked only while out of reset.
`define GVM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define GVM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`else

`define GVM_ASSERT(label, prop, msg)
`define GVM_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// File: hdl/gvm_pkg.sv
// Shared constants, types and codes for the gossip view merge core.
package gvm_pkg;

    localparam int VIEW_SIZE = 5;
    localparam int ID_BITS   = 8;
    localparam int SLOT_BITS = 3;
    localparam int CNT_BITS  = 3;
    // holds counts up to twice the view size (empty plus masked slot indexes)
    localparam int SUM_BITS  = $clog2(2 * VIEW_SIZE + 1);

    localparam logic [ID_BITS-1:0] EMPTY_ID = '1;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_MERGE = 1'b1
    } opcode_t;

    typedef logic [ID_BITS-1:0] id_t;
    typedef id_t [VIEW_SIZE-1:0] view_t;

    typedef struct packed {
        opcode_t                opcode;
        logic [SLOT_BITS-1:0]   slot;
        id_t                    write_id;
        logic [VIEW_SIZE-1:0]   sent_mask;
        logic [CNT_BITS-1:0]    recv_count;
        view_t                  recv;
    } item_t;

endpackage

// File: hdl/gvm_merge.sv
// Combinational next-view logic: slot write or merge of received IDs.
module gvm_merge (
    input  gvm_pkg::view_t                  view_i,
    input  gvm_pkg::item_t                  item_i,
    output gvm_pkg::view_t                  view_o,
    output logic [gvm_pkg::CNT_BITS-1:0]    dropped_o
);

    localparam int VS = gvm_pkg::VIEW_SIZE;
    localparam int SB = gvm_pkg::SUM_BITS;

    logic [SB-1:0]  cnt;
    logic [VS-1:0]  hit [VS];
    logic [VS-1:0]  first_hit [VS];
    logic [VS-1:0]  new_flag;
    logic [VS-1:0]  clear_mask;
    logic [VS-1:0]  mark;
    logic [VS-1:0]  empty_flag;
    logic [SB-1:0]  pos [VS];
    logic [SB-1:0]  e_idx [VS];
    logic [SB-1:0]  m_idx [VS];
    logic [SB-1:0]  pending;
    logic [SB-1:0]  n_empty;
    logic [SB-1:0]  n_mark;
    logic [SB-1:0]  placed_empty;
    logic [SB-1:0]  remain;
    logic [SB-1:0]  placed_mark;
    gvm_pkg::view_t fresh;
    gvm_pkg::view_t merged;

    // pick entry idx of a packed ID list
    function automatic gvm_pkg::id_t pick(gvm_pkg::view_t arr, logic [SB-1:0] idx);
        gvm_pkg::id_t r;
        r = gvm_pkg::EMPTY_ID;
        for (int k = 0; k < VS; k++) begin
            if (idx == SB'(k)) begin
                r = arr[k];
            end
        end
        return r;
    endfunction

    // clamp the received count to the view size
    always_comb begin
        if ({1'b0, item_i.recv_count} > (gvm_pkg::CNT_BITS + 1)'(VS)) begin
            cnt = SB'(VS);
        end else begin
            cnt = SB'(item_i.recv_count);
        end
    end

    // known-ID check against the old view, first match clears its mask bit
    always_comb begin
        clear_mask = '0;
        new_flag   = '0;
        for (int i = 0; i < VS; i++) begin
            for (int s = 0; s < VS; s++) begin
                hit[i][s] = (view_i[s] == item_i.recv[i]);
            end
            first_hit[i] = hit[i] & (~hit[i] + VS'(1));
            if (SB'(i) < cnt) begin
                if (|hit[i]) begin
                    clear_mask = clear_mask | first_hit[i];
                end else begin
                    new_flag[i] = 1'b1;
                end
            end
        end
        mark = item_i.sent_mask & ~clear_mask;
    end

    // compact new IDs in arrival order
    always_comb begin
        pending = '0;
        fresh   = {VS{gvm_pkg::EMPTY_ID}};
        for (int i = 0; i < VS; i++) begin
            pos[i]  = pending;
            pending = pending + SB'(new_flag[i]);
        end
        for (int i = 0; i < VS; i++) begin
            for (int k = 0; k < VS; k++) begin
                if (new_flag[i] && pos[i] == SB'(k)) begin
                    fresh[k] = item_i.recv[i];
                end
            end
        end
    end

    // prefix counts of empty and masked slots
    always_comb begin
        n_empty = '0;
        n_mark  = '0;
        for (int s = 0; s < VS; s++) begin
            empty_flag[s] = (view_i[s] == gvm_pkg::EMPTY_ID);
            e_idx[s] = n_empty;
            m_idx[s] = n_mark;
            n_empty  = n_empty + SB'(empty_flag[s]);
            n_mark   = n_mark + SB'(mark[s]);
        end
        placed_empty = (n_empty < pending) ? n_empty : pending;
        remain       = pending - placed_empty;
        placed_mark  = (n_mark < remain) ? n_mark : remain;
    end

    // fill empty slots, then overwrite masked slots, taking new IDs from the back
    always_comb begin
        for (int s = 0; s < VS; s++) begin
            merged[s] = view_i[s];
            if (empty_flag[s] && e_idx[s] < pending) begin
                merged[s] = pick(fresh, pending - SB'(1) - e_idx[s]);
            end
            if (mark[s] && (placed_empty + m_idx[s]) < pending) begin
                merged[s] = pick(fresh, pending - SB'(1) - placed_empty - m_idx[s]);
            end
        end
    end

    // result select by opcode
    always_comb begin
        view_o    = view_i;
        dropped_o = '0;
        case (item_i.opcode)
            gvm_pkg::OP_WRITE: begin
                for (int s = 0; s < VS; s++) begin
                    if ({1'b0, item_i.slot} == (gvm_pkg::SLOT_BITS + 1)'(s)) begin
                        view_o[s] = item_i.write_id;
                    end
                end
            end
            gvm_pkg::OP_MERGE: begin
                view_o    = merged;
                dropped_o = gvm_pkg::CNT_BITS'(remain - placed_mark);
            end
            default: begin
                view_o    = view_i;
                dropped_o = '0;
            end
        endcase
    end

endmodule

// File: hdl/gossip_view_merge_core.sv
// An accepted item is held in the input register until the result register can take it.
// Throughput: one item per cycle while the result is not stalled; the view update for an
// item, one pass of the merge logic between the input register and the view/result registers, sets it.
// A stalled result holds the input register; once that register is full, s_ready drops.
// Reset (aresetn low, synchronous) empties every view slot and drops both stages.
`include "gossip_view_merge_core_macros.svh"

module gossip_view_merge_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_opcode,
    input  logic [gvm_pkg::SLOT_BITS-1:0]   s_slot,
    input  logic [gvm_pkg::ID_BITS-1:0]     s_write_id,
    input  logic [gvm_pkg::VIEW_SIZE-1:0]   s_sent_mask,
    input  logic [gvm_pkg::CNT_BITS-1:0]    s_recv_count,
    input  logic [gvm_pkg::ID_BITS-1:0]     s_recv_0,
    input  logic [gvm_pkg::ID_BITS-1:0]     s_recv_1,
    input  logic [gvm_pkg::ID_BITS-1:0]     s_recv_2,
    input  logic [gvm_pkg::ID_BITS-1:0]     s_recv_3,
    input  logic [gvm_pkg::ID_BITS-1:0]     s_recv_4,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [gvm_pkg::ID_BITS-1:0]     m_view_0,
    output logic [gvm_pkg::ID_BITS-1:0]     m_view_1,
    output logic [gvm_pkg::ID_BITS-1:0]     m_view_2,
    output logic [gvm_pkg::ID_BITS-1:0]     m_view_3,
    output logic [gvm_pkg::ID_BITS-1:0]     m_view_4,
    output logic [gvm_pkg::CNT_BITS-1:0]    m_dropped_count
);

    gvm_pkg::item_t                 in_item;
    gvm_pkg::item_t                 in_item_reg;
    logic                           in_valid_reg;
    logic                           in_valid_next;
    gvm_pkg::view_t                 view_reg;
    gvm_pkg::view_t                 view_next;
    gvm_pkg::view_t                 out_view_reg;
    logic [gvm_pkg::CNT_BITS-1:0]   out_drop_reg;
    logic [gvm_pkg::CNT_BITS-1:0]   drop_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic                           in_take;
    logic                           adv;

    // pack the input ports into one item
    always_comb begin
        in_item.opcode     = gvm_pkg::opcode_t'(s_opcode);
        in_item.slot       = s_slot;
        in_item.write_id   = s_write_id;
        in_item.sent_mask  = s_sent_mask;
        in_item.recv_count = s_recv_count;
        in_item.recv[0]    = s_recv_0;
        in_item.recv[1]    = s_recv_1;
        in_item.recv[2]    = s_recv_2;
        in_item.recv[3]    = s_recv_3;
        in_item.recv[4]    = s_recv_4;
    end

    // flow control: the input stage moves on when the result register is free
    assign adv     = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;
    assign in_take = s_valid && s_ready;

    always_comb begin
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (adv) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (adv) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // next view and dropped count
    gvm_merge u_merge (
        .view_i    (view_reg),
        .item_i    (in_item_reg),
        .view_o    (view_next),
        .dropped_o (drop_next)
    );

    // control and view state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            view_reg      <= {gvm_pkg::VIEW_SIZE{gvm_pkg::EMPTY_ID}};
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (adv) begin
                view_reg <= view_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_item_reg <= in_item;
        end
        if (adv) begin
            out_view_reg <= view_next;
            out_drop_reg <= drop_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_view_0        = out_view_reg[0];
    assign m_view_1        = out_view_reg[1];
    assign m_view_2        = out_view_reg[2];
    assign m_view_3        = out_view_reg[3];
    assign m_view_4        = out_view_reg[4];
    assign m_dropped_count = out_drop_reg;

    // checks
    `GVM_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !in_valid_reg && !out_valid_reg, "reset left a stage valid")
    `GVM_ASSERT(a_in_held, in_valid_reg && !adv |=> in_valid_reg, "pending input item lost")
    `GVM_ASSERT(a_result_mirrors_view, out_valid_reg |-> out_view_reg == view_reg, "result view differs from state")
    `GVM_ASSERT(a_write_no_drop, adv && in_item_reg.opcode == gvm_pkg::OP_WRITE |=> out_drop_reg == '0, "write item reported drops")
    `GVM_ASSERT(a_drop_bound, out_valid_reg |-> out_drop_reg <= gvm_pkg::CNT_BITS'(gvm_pkg::VIEW_SIZE), "dropped count exceeds view size")

endmodule
